[hw/rtl/sik_pkg.sv]
// Shared types, constants and helper functions of the SCARA inverse kinematics core.
// No dependencies; used by sik_atan and scara_inverse_kinematics_core.
package sik_pkg;

    localparam int ANGLE_BITS  = 16;
    localparam int LENGTH_BITS = 16;

    // arm geometry in 1/16 mm
    localparam longint FORE_LEN  = 2272;
    localparam longint UPPER_LEN = 3120;
    localparam longint ARM_SQ    = FORE_LEN * FORE_LEN + UPPER_LEN * UPPER_LEN;
    localparam longint K_REACH   = 2 * FORE_LEN * UPPER_LEN;
    localparam longint BK        = UPPER_LEN * K_REACH;
    localparam longint D3_OFFSET = 410 * 16 - 70 * 16;

    // atan2 unit
    localparam int ATAN_IN_W    = 40;
    localparam int CORDIC_W     = 45;
    localparam int NORM_EXP     = 40;
    localparam int NORM_STAGES  = 7;
    localparam int CORDIC_STEPS = 31;
    localparam int ATAN_LAT     = 1 + NORM_STAGES + CORDIC_STEPS + 1;
    localparam logic [31:0] ACC_HALF = 32'h8000_0000;

    localparam int SQRT_STAGES = 25;
    localparam int PROD_W      = 2 * SQRT_STAGES;

    localparam logic [31:0] TURN_TAB [0:CORDIC_STEPS-1] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
        32'h00000001
    };

    // configuration register indexes
    localparam logic [2:0] CFG_SHOULDER = 3'd0;
    localparam logic [2:0] CFG_ELBOW    = 3'd1;
    localparam logic [2:0] CFG_WRIST    = 3'd2;
    localparam logic [2:0] CFG_STROKE_L = 3'd3;
    localparam logic [2:0] CFG_STROKE_H = 3'd4;

    localparam logic [14:0] RST_SHOULDER = 15'd27307;
    localparam logic [14:0] RST_ELBOW    = 15'd18204;
    localparam logic [14:0] RST_WRIST    = 15'd29127;
    localparam logic [15:0] RST_STROKE_L = 16'hF380;
    localparam logic [15:0] RST_STROKE_H = 16'hF9C0;

    typedef struct packed {
        logic signed [15:0] wrist_x;
        logic signed [15:0] wrist_y;
        logic signed [15:0] wrist_z;
        logic signed [15:0] wrist_phi;
        logic signed [15:0] now_theta1;
        logic signed [15:0] now_theta2;
        logic signed [15:0] now_d3;
        logic signed [15:0] now_theta4;
    } t_sik_in;

    typedef struct packed {
        logic signed [15:0] first_theta1;
        logic signed [15:0] first_theta2;
        logic signed [15:0] first_theta4;
        logic               first_ok;
        logic signed [15:0] second_theta1;
        logic signed [15:0] second_theta2;
        logic signed [15:0] second_theta4;
        logic               second_ok;
        logic signed [15:0] prism_d3;
        logic               reachable;
    } t_sik_out;

    typedef struct packed {
        logic signed [15:0] wrist_phi;
        logic signed [15:0] now_theta1;
        logic signed [15:0] now_theta2;
        logic signed [15:0] now_d3;
        logic signed [15:0] now_theta4;
        logic signed [15:0] d3o;
        logic               d3_ok;
        logic               reach;
    } t_sik_side;

    typedef struct packed {
        logic signed [15:0] theta1;
        logic signed [15:0] theta2;
        logic signed [15:0] theta4;
    } t_sik_sol;

    function automatic logic sik_within(logic signed [15:0] a, logic [14:0] lim);
        logic [15:0] m;
        m = a[15] ? 16'(-a) : a;
        return (m <= {1'b0, lim});
    endfunction

    function automatic logic [16:0] sik_dist(logic signed [15:0] a, logic signed [15:0] b);
        logic signed [16:0] d;
        d = 17'(a) - 17'(b);
        return d[16] ? 17'(-d) : 17'(d);
    endfunction

endpackage

[hw/rtl/scara_inverse_kinematics_core.sv]
// SCARA inverse kinematics core: both elbow solutions, limit checks and ordering.
// Depends on sik_pkg and sik_atan.
// One pose is taken per cycle while o_in_ready is high; the pipeline holds while it is low.
// The depth comes from the 25-stage bit-per-stage square root and the three parallel
// atan2 units (40 stages each: shift search, 31 CORDIC steps, rounding). A two-entry
// output buffer lets one result wait while the pipeline keeps taking poses;
// o_in_ready drops only when both entries are full.
module scara_inverse_kinematics_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  sik_pkg::t_sik_in  i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output sik_pkg::t_sik_out o_out_data,
    input  logic              i_cfg_we,
    input  logic [2:0]        i_cfg_idx,
    input  logic [15:0]       i_cfg_data
);
    localparam int SQ  = sik_pkg::SQRT_STAGES;
    localparam int PW  = sik_pkg::PROD_W;
    localparam int AL  = sik_pkg::ATAN_LAT;
    localparam int AIW = sik_pkg::ATAN_IN_W;
    localparam logic signed [32:0] K33 = 33'(sik_pkg::K_REACH);

    // configuration
    logic [14:0] r_shoulder_limit, r_elbow_limit, r_wrist_limit;
    logic [15:0] r_stroke_low, r_stroke_high;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shoulder_limit <= sik_pkg::RST_SHOULDER;
            r_elbow_limit    <= sik_pkg::RST_ELBOW;
            r_wrist_limit    <= sik_pkg::RST_WRIST;
            r_stroke_low     <= sik_pkg::RST_STROKE_L;
            r_stroke_high    <= sik_pkg::RST_STROKE_H;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                sik_pkg::CFG_SHOULDER: r_shoulder_limit <= i_cfg_data[14:0];
                sik_pkg::CFG_ELBOW:    r_elbow_limit    <= i_cfg_data[14:0];
                sik_pkg::CFG_WRIST:    r_wrist_limit    <= i_cfg_data[14:0];
                sik_pkg::CFG_STROKE_L: r_stroke_low     <= i_cfg_data;
                sik_pkg::CFG_STROKE_H: r_stroke_high    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic adv;
    logic r_sv, r_ov;
    assign adv        = !r_sv;
    assign o_in_ready = adv;

    // stage 0: input register
    logic             r_v0;
    sik_pkg::t_sik_in r_in0;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v0 <= 1'b0;
        else if (adv) r_v0 <= i_in_valid;
    end
    always_ff @(posedge i_clk) begin
        if (adv) r_in0 <= i_in_data;
    end

    // stage 1: squares, prismatic joint
    logic signed [17:0] s1_d3;
    logic signed [15:0] s1_d3o;
    logic               s1_d3_ok;
    logic signed [31:0] s1_xx, s1_yy;
    sik_pkg::t_sik_side s1_side;

    assign s1_d3 = -18'($signed(r_in0.wrist_z)) - 18'(sik_pkg::D3_OFFSET);
    assign s1_xx = $signed(r_in0.wrist_x) * $signed(r_in0.wrist_x);
    assign s1_yy = $signed(r_in0.wrist_y) * $signed(r_in0.wrist_y);

    always_comb begin
        if (s1_d3 < -18'sd32768)     s1_d3o = 16'sh8000;
        else if (s1_d3 > 18'sd32767) s1_d3o = 16'sh7FFF;
        else                         s1_d3o = s1_d3[15:0];
        s1_d3_ok = (s1_d3 >= 18'($signed(r_stroke_low)))
                && (s1_d3 <= 18'($signed(r_stroke_high)));
        s1_side.wrist_phi  = r_in0.wrist_phi;
        s1_side.now_theta1 = r_in0.now_theta1;
        s1_side.now_theta2 = r_in0.now_theta2;
        s1_side.now_d3     = r_in0.now_d3;
        s1_side.now_theta4 = r_in0.now_theta4;
        s1_side.d3o        = s1_d3o;
        s1_side.d3_ok      = s1_d3_ok;
        s1_side.reach      = 1'b0;
    end

    logic               r_v1;
    logic [30:0]        r_xx1, r_yy1;
    logic signed [15:0] r_x1, r_y1;
    sik_pkg::t_sik_side r_side1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v1 <= 1'b0;
        else if (adv) r_v1 <= r_v0;
    end
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_xx1   <= s1_xx[30:0];
            r_yy1   <= s1_yy[30:0];
            r_x1    <= r_in0.wrist_x;
            r_y1    <= r_in0.wrist_y;
            r_side1 <= s1_side;
        end
    end

    // stage 2: law of cosines numerator, reach test
    logic signed [32:0] s2_n;
    logic               s2_reach;
    sik_pkg::t_sik_side s2_side;
    assign s2_n     = $signed(33'(r_xx1) + 33'(r_yy1)) - 33'(sik_pkg::ARM_SQ);
    assign s2_reach = (s2_n >= -K33) && (s2_n <= K33);
    always_comb begin
        s2_side       = r_side1;
        s2_side.reach = s2_reach;
    end

    logic               r_v2;
    logic signed [25:0] r_n2;
    logic signed [15:0] r_x2, r_y2;
    sik_pkg::t_sik_side r_side2;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v2 <= 1'b0;
        else if (adv) r_v2 <= r_v1;
    end
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_n2    <= s2_reach ? s2_n[25:0] : '0;
            r_x2    <= r_x1;
            r_y2    <= r_y1;
            r_side2 <= s2_side;
        end
    end

    // stage 3: k - n, k + n
    logic signed [25:0] s3_km, s3_kp;
    assign s3_km = 26'(sik_pkg::K_REACH) - r_n2;
    assign s3_kp = 26'(sik_pkg::K_REACH) + r_n2;

    logic               r_v3;
    logic [SQ-1:0]      r_km3, r_kp3;
    logic signed [25:0] r_n3;
    logic signed [15:0] r_x3, r_y3;
    sik_pkg::t_sik_side r_side3;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v3 <= 1'b0;
        else if (adv) r_v3 <= r_v2;
    end
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_km3   <= s3_km[SQ-1:0];
            r_kp3   <= s3_kp[SQ-1:0];
            r_n3    <= r_n2;
            r_x3    <= r_x2;
            r_y3    <= r_y2;
            r_side3 <= r_side2;
        end
    end

    // stage 4: radicand
    logic               r_v4;
    logic [PW-1:0]      r_prod4;
    logic signed [25:0] r_n4;
    logic signed [15:0] r_x4, r_y4;
    sik_pkg::t_sik_side r_side4;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v4 <= 1'b0;
        else if (adv) r_v4 <= r_v3;
    end
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_prod4 <= r_km3 * r_kp3;
            r_n4    <= r_n3;
            r_x4    <= r_x3;
            r_y4    <= r_y3;
            r_side4 <= r_side3;
        end
    end

    // square root, one result bit per stage
    logic               r_qv    [0:SQ-1];
    logic [PW-1:0]      r_qrem  [0:SQ-1];
    logic [SQ-1:0]      r_qroot [0:SQ-1];
    logic signed [25:0] r_qn    [0:SQ-1];
    logic signed [15:0] r_qx    [0:SQ-1];
    logic signed [15:0] r_qy    [0:SQ-1];
    sik_pkg::t_sik_side r_qside [0:SQ-1];

    for (genvar k = 0; k < SQ; k++) begin : g_sqrt
        localparam int B = SQ - 1 - k;
        logic               v_in;
        logic [PW-1:0]      rem_in;
        logic [SQ-1:0]      root_in;
        logic signed [25:0] n_in;
        logic signed [15:0] x_in, y_in;
        sik_pkg::t_sik_side side_in;
        logic [PW+1:0]      trial;
        logic               ge;

        if (k == 0) begin : g_head
            assign v_in    = r_v4;
            assign rem_in  = r_prod4;
            assign root_in = '0;
            assign n_in    = r_n4;
            assign x_in    = r_x4;
            assign y_in    = r_y4;
            assign side_in = r_side4;
        end else begin : g_body
            assign v_in    = r_qv[k-1];
            assign rem_in  = r_qrem[k-1];
            assign root_in = r_qroot[k-1];
            assign n_in    = r_qn[k-1];
            assign x_in    = r_qx[k-1];
            assign y_in    = r_qy[k-1];
            assign side_in = r_qside[k-1];
        end

        assign trial = ((PW+2)'(root_in) << (B + 1)) | ((PW+2)'(1) << (2 * B));
        assign ge    = (PW+2)'(rem_in) >= trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_qv[k] <= 1'b0;
            else if (adv) r_qv[k] <= v_in;
        end
        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_qrem[k]  <= ge ? PW'((PW+2)'(rem_in) - trial) : rem_in;
                r_qroot[k] <= ge ? (root_in | (SQ'(1) << B)) : root_in;
                r_qn[k]    <= n_in;
                r_qx[k]    <= x_in;
                r_qy[k]    <= y_in;
                r_qside[k] <= side_in;
            end
        end
    end

    // stage 5: atan2 operands
    logic                  r_v5;
    logic [SQ-1:0]         r_s5;
    logic signed [25:0]    r_n5;
    logic [36:0]           r_fs5;
    logic signed [AIW-1:0] r_fx5;
    logic signed [15:0]    r_x5, r_y5;
    sik_pkg::t_sik_side    r_side5;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v5 <= 1'b0;
        else if (adv) r_v5 <= r_qv[SQ-1];
    end
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s5    <= r_qroot[SQ-1];
            r_n5    <= r_qn[SQ-1];
            r_fs5   <= 37'(r_qroot[SQ-1]) * 37'(sik_pkg::FORE_LEN);
            r_fx5   <= AIW'(sik_pkg::BK) + AIW'(r_qn[SQ-1]) * AIW'(sik_pkg::FORE_LEN);
            r_x5    <= r_qx[SQ-1];
            r_y5    <= r_qy[SQ-1];
            r_side5 <= r_qside[SQ-1];
        end
    end

    logic signed [15:0] t2_ang, beta_ang, base_ang;

    sik_atan u_atan_t2 (
        .i_clk   (i_clk),
        .i_en    (adv),
        .i_x     (AIW'(r_n5)),
        .i_y     ($signed(AIW'(r_s5))),
        .o_angle (t2_ang)
    );

    sik_atan u_atan_beta (
        .i_clk   (i_clk),
        .i_en    (adv),
        .i_x     (r_fx5),
        .i_y     ($signed(AIW'(r_fs5))),
        .o_angle (beta_ang)
    );

    sik_atan u_atan_base (
        .i_clk   (i_clk),
        .i_en    (adv),
        .i_x     (AIW'(r_x5)),
        .i_y     (AIW'(r_y5)),
        .o_angle (base_ang)
    );

    // side data runs alongside the atan2 units
    logic               r_dv [0:AL-1];
    sik_pkg::t_sik_side r_ds [0:AL-1];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < AL; i++) r_dv[i] <= 1'b0;
        end else if (adv) begin
            r_dv[0] <= r_v5;
            for (int i = 1; i < AL; i++) r_dv[i] <= r_dv[i-1];
        end
    end
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_ds[0] <= r_side5;
            for (int i = 1; i < AL; i++) r_ds[i] <= r_ds[i-1];
        end
    end

    // stage 6: both solutions and limit checks
    sik_pkg::t_sik_side s6_side;
    sik_pkg::t_sik_sol  s6_sol [0:1];
    logic               s6_ok  [0:1];
    assign s6_side = r_ds[AL-1];

    always_comb begin
        s6_sol[0].theta1 = base_ang - beta_ang;
        s6_sol[1].theta1 = base_ang + beta_ang;
        s6_sol[0].theta2 = t2_ang;
        s6_sol[1].theta2 = -t2_ang;
        for (int j = 0; j < 2; j++) begin
            s6_sol[j].theta4 = s6_sol[j].theta1 + s6_sol[j].theta2 - s6_side.wrist_phi;
            s6_ok[j] = s6_side.reach && s6_side.d3_ok
                    && sik_pkg::sik_within(s6_sol[j].theta1, r_shoulder_limit)
                    && sik_pkg::sik_within(s6_sol[j].theta2, r_elbow_limit)
                    && sik_pkg::sik_within(s6_sol[j].theta4, r_wrist_limit);
        end
    end

    logic               r_v6;
    sik_pkg::t_sik_sol  r_sol6 [0:1];
    logic               r_ok6  [0:1];
    sik_pkg::t_sik_side r_side6;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v6 <= 1'b0;
        else if (adv) r_v6 <= r_dv[AL-1];
    end
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_sol6  <= s6_sol;
            r_ok6   <= s6_ok;
            r_side6 <= s6_side;
        end
    end

    // stage 7: distance to current joints
    logic [18:0] s7_sum [0:1];
    always_comb begin
        for (int j = 0; j < 2; j++) begin
            s7_sum[j] = 19'(sik_pkg::sik_dist(r_sol6[j].theta1, r_side6.now_theta1))
                      + 19'(sik_pkg::sik_dist(r_sol6[j].theta2, r_side6.now_theta2))
                      + 19'(sik_pkg::sik_dist(r_side6.d3o, r_side6.now_d3))
                      + 19'(sik_pkg::sik_dist(r_sol6[j].theta4, r_side6.now_theta4));
        end
    end

    logic               r_v7;
    sik_pkg::t_sik_sol  r_sol7 [0:1];
    logic               r_ok7  [0:1];
    logic [18:0]        r_sum7 [0:1];
    sik_pkg::t_sik_side r_side7;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v7 <= 1'b0;
        else if (adv) r_v7 <= r_v6;
    end
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_sol7  <= r_sol6;
            r_ok7   <= r_ok6;
            r_sum7  <= s7_sum;
            r_side7 <= r_side6;
        end
    end

    // stage 8: ordering and result word
    logic              s8_swap;
    sik_pkg::t_sik_sol s8_a, s8_b;
    sik_pkg::t_sik_out s8_out;
    assign s8_swap = r_ok7[0] && r_ok7[1] && (r_sum7[1] < r_sum7[0]);

    always_comb begin
        s8_a = s8_swap ? r_sol7[1] : r_sol7[0];
        s8_b = s8_swap ? r_sol7[0] : r_sol7[1];
        if (!r_side7.reach) begin
            s8_a = '0;
            s8_b = '0;
        end
        s8_out.first_theta1  = s8_a.theta1;
        s8_out.first_theta2  = s8_a.theta2;
        s8_out.first_theta4  = s8_a.theta4;
        s8_out.first_ok      = s8_swap ? r_ok7[1] : r_ok7[0];
        s8_out.second_theta1 = s8_b.theta1;
        s8_out.second_theta2 = s8_b.theta2;
        s8_out.second_theta4 = s8_b.theta4;
        s8_out.second_ok     = s8_swap ? r_ok7[0] : r_ok7[1];
        s8_out.prism_d3      = r_side7.d3o;
        s8_out.reachable     = r_side7.reach;
    end

    logic              r_v8;
    sik_pkg::t_sik_out r_res8;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v8 <= 1'b0;
        else if (adv) r_v8 <= r_v7;
    end
    always_ff @(posedge i_clk) begin
        if (adv) r_res8 <= s8_out;
    end

    // output register plus skid entry
    sik_pkg::t_sik_out r_out, r_skid;
    logic              take;
    assign take = r_ov && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else if (r_sv) begin
            if (take) begin
                r_sv <= 1'b0;
            end
        end else if (!r_ov || take) begin
            r_ov <= r_v8;
        end else if (r_v8) begin
            r_sv <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_sv) begin
            if (take) r_out <= r_skid;
        end else if (!r_ov || take) begin
            r_out <= r_res8;
        end else begin
            r_skid <= r_res8;
        end
    end

    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sv |-> r_ov)
        else $error("skid entry full while output register empty");

    a_unreach_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.reachable) |->
        (!o_out_data.first_ok && !o_out_data.second_ok
         && o_out_data.first_theta1 == 16'sd0 && o_out_data.second_theta1 == 16'sd0))
        else $error("unreachable pose carries a solution");

    a_elbow_mirror: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.reachable) |->
        ((o_out_data.first_theta2 + o_out_data.second_theta2) == 16'd0))
        else $error("elbow angles of the two solutions do not mirror");

    a_ok_in_stroke: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.first_ok) |->
        ($signed(o_out_data.prism_d3) >= $signed(r_stroke_low)
         && $signed(o_out_data.prism_d3) <= $signed(r_stroke_high)))
        else $error("valid solution outside stroke range");

endmodule

[hw/rtl/sik_atan.sv]
// Pipelined atan2: normalizing shift search, 31-step CORDIC vectoring, rounding.
// Depends on sik_pkg. Takes one vector per cycle while i_en is high; all stages hold while it is low.
module sik_atan (
    input  logic                                  i_clk,
    input  logic                                  i_en,
    input  logic signed [sik_pkg::ATAN_IN_W-1:0]  i_x,
    input  logic signed [sik_pkg::ATAN_IN_W-1:0]  i_y,
    output logic signed [sik_pkg::ANGLE_BITS-1:0] o_angle
);
    localparam int W     = sik_pkg::CORDIC_W;
    localparam int NORM  = sik_pkg::NORM_STAGES;
    localparam int STEPS = sik_pkg::CORDIC_STEPS;
    localparam int LAST  = NORM + STEPS;

    logic signed [W-1:0] r_x    [0:LAST];
    logic signed [W-1:0] r_y    [0:LAST];
    logic [31:0]         r_acc  [0:LAST];
    logic                r_zero [0:LAST];
    logic signed [sik_pkg::ANGLE_BITS-1:0] r_angle;

    logic signed [W-1:0] n_x0, n_y0;
    logic [31:0]         n_acc0;
    logic [31:0]         acc_rnd;

    // fold left half plane onto the right
    always_comb begin
        n_x0   = W'(i_x);
        n_y0   = W'(i_y);
        n_acc0 = '0;
        if (i_x[sik_pkg::ATAN_IN_W-1]) begin
            n_x0   = -W'(i_x);
            n_y0   = -W'(i_y);
            n_acc0 = sik_pkg::ACC_HALF;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]    <= n_x0;
            r_y[0]    <= n_y0;
            r_acc[0]  <= n_acc0;
            r_zero[0] <= (i_x == '0) && (i_y == '0);
        end
    end

    // greedy shift search; last stage doubles once more while still in range
    for (genvar j = 1; j <= NORM; j++) begin : g_norm
        localparam int C  = (j < NORM) ? (1 << (NORM - 1 - j)) : 0;
        localparam int SH = (C == 0) ? 1 : C;
        localparam logic signed [W-1:0] TH = W'(1) << (sik_pkg::NORM_EXP - C);
        logic fits;
        assign fits = (r_x[j-1] < TH) && (r_y[j-1] < TH) && (r_y[j-1] > -TH);
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[j]    <= fits ? (r_x[j-1] <<< SH) : r_x[j-1];
                r_y[j]    <= fits ? (r_y[j-1] <<< SH) : r_y[j-1];
                r_acc[j]  <= r_acc[j-1];
                r_zero[j] <= r_zero[j-1];
            end
        end
    end

    for (genvar i = 0; i < STEPS; i++) begin : g_step
        localparam int P = NORM + i;
        logic signed [W-1:0] dx, dy;
        assign dx = r_x[P] >>> i;
        assign dy = r_y[P] >>> i;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!r_y[P][W-1]) begin
                    r_x[P+1]   <= r_x[P] + dy;
                    r_y[P+1]   <= r_y[P] - dx;
                    r_acc[P+1] <= r_acc[P] + sik_pkg::TURN_TAB[i];
                end else begin
                    r_x[P+1]   <= r_x[P] - dy;
                    r_y[P+1]   <= r_y[P] + dx;
                    r_acc[P+1] <= r_acc[P] - sik_pkg::TURN_TAB[i];
                end
                r_zero[P+1] <= r_zero[P];
            end
        end
    end

    assign acc_rnd = r_acc[LAST] + (32'd1 << (31 - sik_pkg::ANGLE_BITS));

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_angle <= r_zero[LAST] ? '0 : acc_rnd[31 -: sik_pkg::ANGLE_BITS];
        end
    end

    assign o_angle = r_angle;

endmodule
